/* hdl/h2tk_pkg.sv */
// Shared constants, widths and helpers for the 2D histogram top-k report block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package h2tk_pkg;
    localparam int ROWS       = 16;
    localparam int COLS       = 16;
    localparam int COUNT_BITS = 31;
    localparam int ROW_BITS   = 4;
    localparam int COL_BITS   = 4;
    localparam int SUM_BITS   = 35;
    localparam int ADDR_BITS  = $clog2(ROWS * COLS);
    localparam int NUM_BITS   = $clog2(COLS + 1);
    localparam int IDX_BITS   = $clog2(COLS);
    localparam int MAXC_BITS  = 5;
    localparam int EMIT_CAP   = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 31;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_COUNT   = 2'd0,
        KIND_CELL    = 2'd1,
        KIND_SKIPPED = 2'd2,
        KIND_ROW_END = 2'd3
    } kind_t;

    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMIT_LIMIT = 1'd1;

    function automatic logic [ADDR_BITS-1:0] h2tk_addr(input logic [ROW_BITS-1:0] row,
                                                       input logic [IDX_BITS-1:0] col);
        int a;
        begin
            a = int'(row) * COLS + int'(col);
            return ADDR_BITS'(a);
        end
    endfunction
endpackage
`default_nettype wire

/* hdl/h2tk_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
// Depends on h2tk_pkg for field widths.
`default_nettype none
interface h2tk_in_if import h2tk_pkg::*;;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [ROW_BITS-1:0] row_index;
    logic [COL_BITS-1:0] col_index;
    modport source (output valid, output operation, output row_index, output col_index,
                    input ready);
    modport sink   (input valid, input operation, input row_index, input col_index,
                    output ready);
endinterface

interface h2tk_out_if import h2tk_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [1:0]            result_kind;
    logic [COL_BITS-1:0]   cell_column;
    logic [COUNT_BITS-1:0] count_value;
    logic [SUM_BITS-1:0]   skipped_total;
    logic                  last;
    modport source (output valid, output result_kind, output cell_column, output count_value,
                    output skipped_total, output last, input ready);
    modport sink   (input valid, input result_kind, input cell_column, input count_value,
                    input skipped_total, input last, output ready);
endinterface
`default_nettype wire

/* hdl/histogram_2d_topk_report.sv */
// Top level of the 2D histogram with ranked per-row report.
// Depends on h2tk_pkg, h2tk_if (channels) and h2tk_table (counter memory).
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------------------------
//  item_ch   | in  | valid/ready      | operation, row_index, col_index
//  result_ch | out | valid/ready      | result_kind, cell_column, count_value,
//            |     |                  | skipped_total, last
//  cfg       | in  | cfg_wr_en        | cfg_index, cfg_data (threshold, emit limit)
//
// One transaction at a time; item_ch.ready is high only while the sequencer idles.
// Count: read, then modify-write with the result into the output register.
// Report: a read and a write step per column to load the row, a limit step,
// then for every eligible cell a scan over all COLS columns of the shared compare
// unit plus a pick step, one more scan and pick that find nothing, then summary and row end.
// Reset clears the table at once through per-entry valid flags; no sweep.
// A stalled result_ch holds the sequencer at its next emit step.
`default_nettype none
module histogram_2d_topk_report import h2tk_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    h2tk_in_if.sink                       item_ch,
    h2tk_out_if.source                    result_ch,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_CNT_RD, S_CNT_WR, S_LOAD_RD, S_LOAD_WR, S_LIMIT,
        S_SCAN, S_PICK, S_SUMMARY, S_ROW_END
    } state_t;

    state_t                  state_reg;
    logic [COUNT_BITS-1:0]   thresh_reg;
    logic [MAXC_BITS-1:0]    emit_limit_reg;
    logic [ROW_BITS-1:0]     row_reg;
    logic [COL_BITS-1:0]     col_reg;
    logic [IDX_BITS-1:0]     idx_reg;
    logic [COUNT_BITS-1:0]   vals [COLS];
    logic [COLS-1:0]         elig_reg;
    logic [NUM_BITS-1:0]     n_reg;
    logic [NUM_BITS-1:0]     skip_cnt_reg;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [NUM_BITS-1:0]     limit_reg;
    logic [NUM_BITS-1:0]     emitted_reg;
    logic                    found_reg;
    logic [COUNT_BITS-1:0]   best_val_reg;
    logic [IDX_BITS-1:0]     best_col_reg;

    logic                    out_valid_reg;
    logic [1:0]              out_kind_reg;
    logic [COL_BITS-1:0]     out_col_reg;
    logic [COUNT_BITS-1:0]   out_count_reg;
    logic [SUM_BITS-1:0]     out_total_reg;
    logic                    out_last_reg;

    logic                    rd_en;
    logic [ADDR_BITS-1:0]    rd_addr;
    logic [COUNT_BITS-1:0]   rd_data;
    logic                    wr_en;
    logic [COUNT_BITS-1:0]   wr_data;
    logic                    out_free;
    logic                    emit_now;
    logic                    row_ok;
    logic                    cell_ok;
    logic                    load_zero;
    logic                    load_skip;
    logic [COUNT_BITS-1:0]   add_val;
    logic [SUM_BITS:0]       sum_wide;
    logic [SUM_BITS-1:0]     sum_sat;
    logic [NUM_BITS-1:0]     lim_a;
    logic [NUM_BITS-1:0]     lim_b;
    logic [NUM_BITS-1:0]     lim_c;
    logic [COUNT_BITS-1:0]   scan_val;

    h2tk_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (h2tk_addr(row_reg, IDX_BITS'(col_reg))),
        .wr_data (wr_data)
    );

    assign out_free = !out_valid_reg || result_ch.ready;
    assign row_ok   = (int'(row_reg) < ROWS);
    assign cell_ok  = row_ok && (int'(col_reg) < COLS);

    // Load a new result this cycle; the output register then stays valid
    assign emit_now = out_free &&
                      ((state_reg == S_CNT_WR) ||
                       ((state_reg == S_PICK) && found_reg && (emitted_reg < limit_reg)) ||
                       ((state_reg == S_SUMMARY) && (skip_cnt_reg != '0)) ||
                       (state_reg == S_ROW_END));

    // Read the counted cell, or walk the report row one column at a time
    assign rd_en   = (state_reg == S_CNT_RD) || (state_reg == S_LOAD_RD);
    assign rd_addr = (state_reg == S_CNT_RD) ? h2tk_addr(row_reg, IDX_BITS'(col_reg))
                                             : h2tk_addr(row_reg, idx_reg);
    assign wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
    assign wr_en   = (state_reg == S_CNT_WR) && out_free && cell_ok;

    // Classify a loaded cell: empty, below threshold, or eligible for ranking
    assign load_zero = (rd_data == '0);
    assign load_skip = !load_zero && (thresh_reg != '0) && (rd_data < thresh_reg);

    // Shared saturating accumulator for skipped counts
    assign add_val  = (state_reg == S_PICK) ? best_val_reg : rd_data;
    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS+1)'(add_val);
    assign sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

    // Emit limit: zero means cap; clamp to cap and eligible count; cap with skips: cap-1
    always_comb
    begin
        lim_a = (emit_limit_reg == '0) ? NUM_BITS'(EMIT_CAP)
              : ((int'(emit_limit_reg) > EMIT_CAP) ? NUM_BITS'(EMIT_CAP)
                                                   : NUM_BITS'(emit_limit_reg));
        lim_b = (lim_a > n_reg) ? n_reg : lim_a;
        lim_c = lim_b;
        if ((int'(lim_b) == EMIT_CAP) && ((skip_cnt_reg != '0) || (n_reg > lim_b)))
        begin
            lim_c = NUM_BITS'(EMIT_CAP - 1);
        end
    end

    assign scan_val = vals[idx_reg];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD_WR)
        begin
            vals[idx_reg] <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thresh_reg     <= '0;
            emit_limit_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            idx_reg        <= '0;
            elig_reg       <= '0;
            n_reg          <= '0;
            skip_cnt_reg   <= '0;
            sum_reg        <= '0;
            limit_reg      <= '0;
            emitted_reg    <= '0;
            found_reg      <= 1'b0;
            best_val_reg   <= '0;
            best_col_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= '0;
            out_col_reg    <= '0;
            out_count_reg  <= '0;
            out_total_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_THRESHOLD:  thresh_reg     <= COUNT_BITS'(cfg_data);
                    REG_EMIT_LIMIT: emit_limit_reg <= cfg_data[MAXC_BITS-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (out_valid_reg && result_ch.ready && !emit_now)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_ch.valid)
                    begin
                        row_reg      <= item_ch.row_index;
                        col_reg      <= item_ch.col_index;
                        idx_reg      <= '0;
                        elig_reg     <= '0;
                        n_reg        <= '0;
                        skip_cnt_reg <= '0;
                        sum_reg      <= '0;
                        emitted_reg  <= '0;
                        if (item_ch.operation == OP_COUNT)
                        begin
                            state_reg <= S_CNT_RD;
                        end
                        else if (int'(item_ch.row_index) < ROWS)
                        begin
                            state_reg <= S_LOAD_RD;
                        end
                        else
                        begin
                            state_reg <= S_ROW_END;
                        end
                    end
                end
                S_CNT_RD:
                begin
                    state_reg <= S_CNT_WR;
                end
                S_CNT_WR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_COUNT;
                        out_col_reg   <= col_reg;
                        out_count_reg <= cell_ok ? wr_data : '0;
                        out_total_reg <= '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_LOAD_RD:
                begin
                    state_reg <= S_LOAD_WR;
                end
                S_LOAD_WR:
                begin
                    if (load_skip)
                    begin
                        skip_cnt_reg <= skip_cnt_reg + 1'b1;
                        sum_reg      <= sum_sat;
                    end
                    else if (!load_zero)
                    begin
                        elig_reg[idx_reg] <= 1'b1;
                        n_reg             <= n_reg + 1'b1;
                    end
                    if (int'(idx_reg) == COLS - 1)
                    begin
                        state_reg <= S_LIMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_LOAD_RD;
                    end
                end
                S_LIMIT:
                begin
                    limit_reg <= lim_c;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // Strictly greater keeps the lowest column among ties
                    if (elig_reg[idx_reg] && (!found_reg || (scan_val > best_val_reg)))
                    begin
                        found_reg    <= 1'b1;
                        best_val_reg <= scan_val;
                        best_col_reg <= idx_reg;
                    end
                    if (int'(idx_reg) == COLS - 1)
                    begin
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_PICK:
                begin
                    if (!found_reg)
                    begin
                        state_reg <= S_SUMMARY;
                    end
                    else if (emitted_reg < limit_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg          <= 1'b1;
                            out_kind_reg           <= KIND_CELL;
                            out_col_reg            <= COL_BITS'(best_col_reg);
                            out_count_reg          <= best_val_reg;
                            out_total_reg          <= '0;
                            out_last_reg           <= 1'b0;
                            emitted_reg            <= emitted_reg + 1'b1;
                            elig_reg[best_col_reg] <= 1'b0;
                            idx_reg                <= '0;
                            found_reg              <= 1'b0;
                            state_reg              <= S_SCAN;
                        end
                    end
                    else
                    begin
                        // Past the limit: fold into the skipped totals
                        skip_cnt_reg           <= skip_cnt_reg + 1'b1;
                        sum_reg                <= sum_sat;
                        elig_reg[best_col_reg] <= 1'b0;
                        idx_reg                <= '0;
                        found_reg              <= 1'b0;
                        state_reg              <= S_SCAN;
                    end
                end
                S_SUMMARY:
                begin
                    if (skip_cnt_reg == '0)
                    begin
                        state_reg <= S_ROW_END;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_SKIPPED;
                        out_col_reg   <= '0;
                        out_count_reg <= COUNT_BITS'(skip_cnt_reg);
                        out_total_reg <= sum_reg;
                        out_last_reg  <= 1'b0;
                        state_reg     <= S_ROW_END;
                    end
                end
                S_ROW_END:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_ROW_END;
                        out_col_reg   <= '0;
                        out_count_reg <= '0;
                        out_total_reg <= '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_ch.ready           = (state_reg == S_IDLE);
    assign result_ch.valid         = out_valid_reg;
    assign result_ch.result_kind   = out_kind_reg;
    assign result_ch.cell_column   = out_col_reg;
    assign result_ch.count_value   = out_count_reg;
    assign result_ch.skipped_total = out_total_reg;
    assign result_ch.last          = out_last_reg;
endmodule
`default_nettype wire

/* hdl/h2tk_table.sv */
// Counter table memory: one write port, one registered read port.
// Per-entry valid flags make never-written entries read as zero after reset.
`default_nettype none
module h2tk_table import h2tk_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_BITS-1:0]  rd_addr,
    output logic      [COUNT_BITS-1:0] rd_data,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_BITS-1:0]  wr_addr,
    input  wire logic [COUNT_BITS-1:0] wr_data
);
    logic [COUNT_BITS-1:0]     mem [ROWS*COLS];
    logic [ROWS*COLS-1:0]      valid_reg;
    logic [COUNT_BITS-1:0]     data_reg;
    logic                      hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;
endmodule
`default_nettype wire
